[sv/bmorph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmorph_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int P_W     = 21;
  localparam int Q_W     = 20;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int TOT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CMP_W   = (TOT_W > P_W) ? TOT_W : P_W;
  localparam int STEP_W  = $clog2(P_W + 1);

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MORPH_MODE   = 2'd2;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic             pix;
    logic [COL_W-1:0] col;
    logic             has_res;
    logic             last;
    logic             interior;
  } item_t;

endpackage

`default_nettype wire

[sv/bmorph_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmorph_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/bmorph_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmorph_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bmorph_pkg::P_W-1:0]    num_a,
  input  wire logic [bmorph_pkg::P_W-1:0]    num_b,
  input  wire logic [bmorph_pkg::WDIM_W-1:0] divisor,
  output logic                              done,
  output logic      [bmorph_pkg::COL_W-1:0]  rem_a,
  output logic      [bmorph_pkg::COL_W-1:0]  rem_b,
  output logic      [bmorph_pkg::Q_W-1:0]    quo_b
);

  import bmorph_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [P_W-1:0]    na_r, na_nxt, nb_r, nb_nxt, qb_r, qb_nxt;
  logic [COL_W-1:0]  ra_r, ra_nxt, rb_r, rb_nxt;
  logic [WDIM_W-1:0] dv_r, dv_nxt;
  logic [COL_W:0]    sa, sb, dv_ext;
  logic              ge_a, ge_b;

  always_comb begin
    dv_ext = (COL_W + 1)'(dv_r);
    sa     = {ra_r, na_r[P_W-1]};
    sb     = {rb_r, nb_r[P_W-1]};
    ge_a   = (sa >= dv_ext);
    ge_b   = (sb >= dv_ext);

    step_nxt = step_r;
    done_nxt = 1'b0;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    qb_nxt   = qb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    dv_nxt   = dv_r;

    if (start) begin
      step_nxt = STEP_W'(P_W);
      na_nxt   = num_a;
      nb_nxt   = num_b;
      qb_nxt   = '0;
      ra_nxt   = '0;
      rb_nxt   = '0;
      dv_nxt   = divisor;
    end else if (step_r != '0) begin
      step_nxt = step_r - STEP_W'(1);
      done_nxt = (step_r == STEP_W'(1));
      na_nxt   = {na_r[P_W-2:0], 1'b0};
      nb_nxt   = {nb_r[P_W-2:0], 1'b0};
      ra_nxt   = ge_a ? COL_W'(sa - dv_ext) : COL_W'(sa);
      rb_nxt   = ge_b ? COL_W'(sb - dv_ext) : COL_W'(sb);
      qb_nxt   = {qb_r[P_W-2:0], ge_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    na_r <= na_nxt;
    nb_r <= nb_nxt;
    qb_r <= qb_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    dv_r <= dv_nxt;
  end

  assign done  = done_r;
  assign rem_a = ra_r;
  assign rem_b = rb_r;
  assign quo_b = qb_r[Q_W-1:0];

endmodule

`default_nettype wire

[sv/bmorph_pos.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmorph_pos (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         advance,
  input  wire logic                         load,
  input  wire logic                         req_type,
  input  wire logic                         pixel_in,
  input  wire logic [bmorph_pkg::WDIM_W-1:0] w,
  input  wire logic [bmorph_pkg::HDIM_W-1:0] h,
  input  wire logic [bmorph_pkg::TOT_W-1:0]  total,
  input  wire logic [bmorph_pkg::COL_W-1:0]  load_col,
  input  wire logic [bmorph_pkg::COL_W-1:0]  load_x,
  input  wire logic [bmorph_pkg::Q_W-1:0]    load_y,
  output bmorph_pkg::item_t                  item,
  output logic      [bmorph_pkg::P_W-1:0]    p_cnt,
  output logic      [bmorph_pkg::Q_W-1:0]    q_cnt
);

  import bmorph_pkg::*;

  logic [P_W-1:0]    p_r, p_nxt, p_inc;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [COL_W-1:0]  x_r, x_nxt;
  logic [Q_W-1:0]    y_r, y_nxt;
  logic [CMP_W-1:0]  p_ext, tot_ext;
  logic [WDIM_W-1:0] col_inc, x_inc;
  logic              x_wrap;

  always_comb begin
    p_ext   = CMP_W'(p_r);
    tot_ext = CMP_W'(total);
    p_inc   = p_r + P_W'(1);
    col_inc = WDIM_W'(col_r) + WDIM_W'(1);
    x_inc   = WDIM_W'(x_r) + WDIM_W'(1);
    x_wrap  = (x_inc == w);

    item.pix      = (req_type == REQ_PIXEL) && (p_ext < tot_ext) && pixel_in;
    item.col      = col_r;
    item.has_res  = (p_ext >= CMP_W'(w) + CMP_W'(1));
    item.last     = (CMP_W'(q_r) + CMP_W'(1) >= tot_ext);
    item.interior = (x_r != '0) && ((WDIM_W + 1)'(x_r) + (WDIM_W + 1)'(2) <= (WDIM_W + 1)'(w))
                 && (y_r != '0) && ((Q_W + 1)'(y_r) + (Q_W + 1)'(2) <= (Q_W + 1)'(h));

    p_nxt   = p_r;
    col_nxt = col_r;
    q_nxt   = q_r;
    x_nxt   = x_r;
    y_nxt   = y_r;

    if (load) begin
      col_nxt = load_col;
      x_nxt   = load_x;
      y_nxt   = load_y;
    end else if (advance) begin
      if (item.has_res && item.last) begin
        p_nxt   = '0;
        col_nxt = '0;
        q_nxt   = '0;
        x_nxt   = '0;
        y_nxt   = '0;
      end else begin
        p_nxt   = p_inc;
        col_nxt = ((p_inc == '0) || (col_inc == w)) ? '0 : COL_W'(col_inc);
        if (item.has_res) begin
          q_nxt = q_r + Q_W'(1);
          x_nxt = x_wrap ? '0 : COL_W'(x_inc);
          y_nxt = x_wrap ? y_r + Q_W'(1) : y_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= '0;
      col_r <= '0;
      q_r   <= '0;
      x_r   <= '0;
      y_r   <= '0;
    end else begin
      p_r   <= p_nxt;
      col_r <= col_nxt;
      q_r   <= q_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

  assign p_cnt = p_r;
  assign q_cnt = q_r;

endmodule

`default_nettype wire

[sv/binary_morphology_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 binary erosion or dilation, one mask pixel per clock in raster order while
// the output is not stalled and no recompute is running. Each accepted beat is registered
// together with its column lookup in a two-row line buffer RAM and then moves on to the
// result register. A result belongs to the pixel frame_width+1 beats back, so after a frame
// the host sends frame_width+1 flush beats; the last result of the frame carries
// frame_last and the counters rewind. After reset all 1024 line buffer columns are cleared
// with in_ready low. Any register write is followed by a position recompute (a bit-serial
// divide), during which in_ready is low; cfg_ready is always high. Pixels on the frame
// border pass through unchanged.

module binary_morphology_3x3 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic                        in_pixel_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_pixel_out,
  output logic                             out_frame_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bmorph_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [bmorph_pkg::CFG_W-1:0] cfg_data
);

  import bmorph_pkg::*;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic              pend_r, pend_nxt;
  logic [WDIM_W-1:0] w_r;
  logic [HDIM_W-1:0] h_r;
  logic [TOT_W-1:0]  total_r;
  logic              mode_r;

  item_t             cur_item;
  item_t             s1_item_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              fwd_r;
  logic [1:0]        fwd_word_r;
  logic [8:0]        win_r, win_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_pix_r, out_last_r;

  logic              accept, s1_go, cfg_wr, div_start, div_done, filtered;
  logic [P_W-1:0]    p_cnt;
  logic [Q_W-1:0]    q_cnt;
  logic [COL_W-1:0]  div_rem_a, div_rem_b;
  logic [Q_W-1:0]    div_quo_b;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [1:0]        ram_wdata, ram_rdata, run_word, line_word;
  logic [2:0]        triple;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WDIM_W'(MAX_WIDTH);
      h_r    <= HDIM_W'(MAX_HEIGHT);
      mode_r <= MODE_ERODE;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_r <= (cfg_data == '0) ? WDIM_W'(1) :
                 ((int'(cfg_data) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(cfg_data));
        end
        REG_FRAME_HEIGHT: begin
          h_r <= (cfg_data == '0) ? HDIM_W'(1) :
                 ((int'(cfg_data) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(cfg_data));
        end
        REG_MORPH_MODE: begin
          mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOT_W'(MAX_WIDTH * MAX_HEIGHT);
    end else if (div_start) begin
      total_r <= TOT_W'(w_r) * TOT_W'(h_r);
    end
  end

  assign s1_go    = s1_valid_r && (!s1_item_r.has_res || !out_valid_r || out_ready);
  assign in_ready = (state_r == ST_RUN) && !pend_r && (!s1_valid_r || s1_go);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    div_start    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pend_r && !s1_valid_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    pend_nxt = cfg_wr ? 1'b1 : (div_start ? 1'b0 : pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
    end
  end

  bmorph_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_a   (p_cnt),
    .num_b   (P_W'(q_cnt)),
    .divisor (w_r),
    .done    (div_done),
    .rem_a   (div_rem_a),
    .rem_b   (div_rem_b),
    .quo_b   (div_quo_b)
  );

  bmorph_pos u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (accept),
    .load     (div_done),
    .req_type (in_req_type),
    .pixel_in (in_pixel_in),
    .w        (w_r),
    .h        (h_r),
    .total    (total_r),
    .load_col (div_rem_a),
    .load_x   (div_rem_b),
    .load_y   (div_quo_b),
    .item     (cur_item),
    .p_cnt    (p_cnt),
    .q_cnt    (q_cnt)
  );

  // Line buffer word: bit 0 holds the row two above, bit 1 the row above.
  always_comb begin
    line_word = fwd_r ? fwd_word_r : ram_rdata;
    run_word  = {s1_item_r.pix, line_word[1]};
    triple    = {s1_item_r.pix, line_word[1], line_word[0]};
    win_nxt   = {win_r[5:0], triple};
    if (!s1_item_r.interior) begin
      filtered = win_nxt[4];
    end else if (mode_r == MODE_DILATE) begin
      filtered = |win_nxt;
    end else begin
      filtered = &win_nxt;
    end
    ram_we    = (state_r == ST_CLEAR) || s1_go;
    ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : s1_item_r.col;
    ram_wdata = (state_r == ST_CLEAR) ? 2'b00 : run_word;

    s1_valid_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_go && s1_item_r.has_res) ? 1'b1 :
                    (out_ready ? 1'b0 : out_valid_r);
  end

  bmorph_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cur_item.col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      win_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fwd_r <= s1_go && (s1_item_r.col == cur_item.col);
      end
      if (s1_go) begin
        win_r <= win_nxt;
      end
    end
    if (accept) begin
      s1_item_r  <= cur_item;
      fwd_word_r <= run_word;
    end
    if (s1_go && s1_item_r.has_res) begin
      out_pix_r  <= filtered;
      out_last_r <= s1_item_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

[sv/bmorph_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmorph_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_pixel_out,
  input wire logic out_frame_last,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) && $stable(out_frame_last))
    else $error("result beat changed while stalled");

  // A new result beat must have an accepted input beat behind it.
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // A register write blocks input until positions are recomputed.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken right after a register write");

  // The line buffer clear keeps input closed right after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("input open during line buffer clear");

endmodule

bind binary_morphology_3x3 bmorph_chk u_bmorph_chk (.*);

`default_nettype wire
